### rtl/core/tcc_pkg.sv
`default_nettype none
package tcc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int IN_FRAC     = 12;
    localparam int OUT_FRAC    = 16;
    localparam int SCALE_SH    = OUT_FRAC - IN_FRAC;

    // Vertex differences, their products and the sums of squares.
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SQ_W    = 2 * COORD_WIDTH + 2;
    localparam int HALF_W  = SQ_W / 2;
    localparam int HIGH_W  = SQ_W - HALF_W;
    localparam int PART_W  = HIGH_W + 1 + DIFF_W;
    localparam int CROSS_W = SQ_W + DIFF_W + 1;
    localparam int DET_W   = 2 * COORD_WIDTH + 4;
    localparam int NUM_W   = 3 * COORD_WIDTH + 9;
    localparam int QUO_W   = NUM_W + 1;

    // Result formats.
    localparam int CEN_W   = 32;
    localparam int RAD_W   = 40;
    localparam int MAG_W   = 41;
    localparam int OFS_W   = 42;
    localparam int CSUM_W  = 44;
    localparam int SQR_W   = 29;
    localparam int RSQ_W   = 2 * SQR_W;
    localparam int RSUM_W  = RSQ_W + 1;

    localparam logic [QUO_W-1:0]  OFS_LIMIT = QUO_W'(64'd1 << 40);
    localparam logic [RAD_W-1:0]  RAD_MAX   = {RAD_W{1'b1}};
    localparam logic [RSUM_W-1:0] RAD_HALF  = RSUM_W'(1) << (OUT_FRAC - 1);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by_coord;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
    } tcc_in_t;

    typedef struct packed {
        logic signed [CEN_W-1:0] center_x;
        logic signed [CEN_W-1:0] center_y;
        logic [RAD_W-1:0]        radius_sq;
        logic                    degenerate;
        logic                    saturated;
    } tcc_out_t;

    // Front end to divider: numerator magnitudes, quotient signs, divisor.
    typedef struct packed {
        logic [NUM_W-1:0]              nmx;
        logic [NUM_W-1:0]              nmy;
        logic                          negx;
        logic                          negy;
        logic [DET_W-1:0]              dm;
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic                          degen;
    } tcc_num_t;

    // Divider to back end: truncated quotients and remainders.
    typedef struct packed {
        logic [NUM_W-1:0]              qx;
        logic [NUM_W-1:0]              qy;
        logic [DET_W-1:0]              rx;
        logic [DET_W-1:0]              ry;
        logic                          negx;
        logic                          negy;
        logic [DET_W-1:0]              dm;
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic                          degen;
    } tcc_quo_t;

    // Pipeline control shared by every stage.
    typedef struct packed {
        logic adv;
    } tcc_ctl_t;

endpackage
`default_nettype wire

### rtl/core/triangle_circumcircle.sv
// Circumcircle of a 2D triangle. Each transaction on the s_ channel carries three vertices
// in signed Q3.12; each gives exactly one transaction on the m_ channel with the
// circumcentre in signed Q15.16, the squared circumradius in unsigned Q24.16 and two
// flags: degenerate (collinear vertices, all results zero) and saturated (a result was
// clipped). The block is fully pipelined and takes a new triangle on every clock cycle
// while the output is not stalled. Its stages form the differences, products and
// numerators, then a restoring divider yields the quotients one bit at a time
// (NUM_W = 3 * COORD_WIDTH + 9 bits), then rounding, centre and radius stages follow,
// the last of which is the output register.
`default_nettype none
module triangle_circumcircle (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire tcc_pkg::tcc_in_t   s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output tcc_pkg::tcc_out_t       m_data
);

    // The whole pipeline moves as one: it advances whenever the output register is
    // empty or its transaction is being taken, so a stall freezes every stage in place
    // and nothing is lost or repeated.
    tcc_pkg::tcc_ctl_t ctl;
    logic              f_valid, d_valid;
    tcc_pkg::tcc_num_t f_data;
    tcc_pkg::tcc_quo_t d_data;

    assign ctl.adv = !m_valid || m_ready;
    assign s_ready = ctl.adv;

    // Differences, squares, determinant and the two Cramer numerators.
    tcc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .in_valid (s_valid),
        .in_data  (s_data),
        .out_valid(f_valid),
        .out_data (f_data)
    );

    // Two restoring dividers side by side, one quotient bit per stage.
    tcc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .in_valid (f_valid),
        .in_data  (f_data),
        .out_valid(d_valid),
        .out_data (d_data)
    );

    // Rounding, centre saturation, squared radius and the output register.
    tcc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .in_valid (d_valid),
        .in_data  (d_data),
        .out_valid(m_valid),
        .out_data (m_data)
    );

    // A degenerate triangle always reports zero results and no saturation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.degenerate) |-> (m_data.center_x == '0 && m_data.center_y == '0
            && m_data.radius_sq == '0 && !m_data.saturated))
        else $error("degenerate result carries non-zero fields");

    // A stalled output must hold the input side off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while the output is stalled");

    // A result that is not taken stays on the port, unchanged, until it is.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result dropped or changed");

endmodule
`default_nettype wire

### rtl/core/tcc_front.sv
`default_nettype none
module tcc_front (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire tcc_pkg::tcc_ctl_t   ctl,
    input  wire                      in_valid,
    input  wire tcc_pkg::tcc_in_t    in_data,
    output logic                     out_valid,
    output tcc_pkg::tcc_num_t        out_data
);

    localparam int W = tcc_pkg::COORD_WIDTH;

    typedef struct packed {
        logic signed [tcc_pkg::DIFF_W-1:0] ux, uy, vx, vy;
        logic signed [W-1:0]               ax, ay;
    } st1_t;

    typedef struct packed {
        logic signed [tcc_pkg::PROD_W-1:0] uxux, uyuy, vxvx, vyvy, uxvy, uyvx;
        logic signed [tcc_pkg::DIFF_W-1:0] ux, uy, vx, vy;
        logic signed [W-1:0]               ax, ay;
    } st2_t;

    typedef struct packed {
        logic [tcc_pkg::SQ_W-1:0]          uu, vv;
        logic signed [tcc_pkg::DET_W-1:0]  det;
        logic signed [tcc_pkg::DIFF_W-1:0] ux, uy, vx, vy;
        logic signed [W-1:0]               ax, ay;
    } st3_t;

    // Low and high partial products of the four long multiplications.
    typedef struct packed {
        logic signed [tcc_pkg::PART_W-1:0] l_uuvy, h_uuvy, l_vvuy, h_vvuy;
        logic signed [tcc_pkg::PART_W-1:0] l_vvux, h_vvux, l_uuvx, h_uuvx;
        logic signed [tcc_pkg::DET_W-1:0]  det;
        logic signed [W-1:0]               ax, ay;
    } st4_t;

    typedef struct packed {
        logic signed [tcc_pkg::CROSS_W-1:0] uuvy, vvuy, vvux, uuvx;
        logic signed [tcc_pkg::DET_W-1:0]   det;
        logic signed [W-1:0]                ax, ay;
    } st5_t;

    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    st4_t s4_reg, s4_next;
    st5_t s5_reg, s5_next;
    tcc_pkg::tcc_num_t s6_reg, s6_next;
    logic [5:0] vld_reg;

    function automatic logic signed [tcc_pkg::PART_W-1:0] part_mul(
        input logic [tcc_pkg::HIGH_W-1:0]        a,
        input logic signed [tcc_pkg::DIFF_W-1:0] b
    );
        logic signed [tcc_pkg::HIGH_W:0] as;
        as = $signed({1'b0, a});
        return tcc_pkg::PART_W'(as * b);
    endfunction

    function automatic logic signed [tcc_pkg::CROSS_W-1:0] join_parts(
        input logic signed [tcc_pkg::PART_W-1:0] lo,
        input logic signed [tcc_pkg::PART_W-1:0] hi
    );
        return (tcc_pkg::CROSS_W'(hi) <<< tcc_pkg::HALF_W) + tcc_pkg::CROSS_W'(lo);
    endfunction

    always_comb begin
        s1_next.ux = tcc_pkg::DIFF_W'(in_data.bx) - tcc_pkg::DIFF_W'(in_data.ax);
        s1_next.uy = tcc_pkg::DIFF_W'(in_data.by_coord) - tcc_pkg::DIFF_W'(in_data.ay);
        s1_next.vx = tcc_pkg::DIFF_W'(in_data.cx) - tcc_pkg::DIFF_W'(in_data.ax);
        s1_next.vy = tcc_pkg::DIFF_W'(in_data.cy) - tcc_pkg::DIFF_W'(in_data.ay);
        s1_next.ax = in_data.ax;
        s1_next.ay = in_data.ay;
    end

    always_comb begin
        s2_next.uxux = s1_reg.ux * s1_reg.ux;
        s2_next.uyuy = s1_reg.uy * s1_reg.uy;
        s2_next.vxvx = s1_reg.vx * s1_reg.vx;
        s2_next.vyvy = s1_reg.vy * s1_reg.vy;
        s2_next.uxvy = s1_reg.ux * s1_reg.vy;
        s2_next.uyvx = s1_reg.uy * s1_reg.vx;
        s2_next.ux   = s1_reg.ux;
        s2_next.uy   = s1_reg.uy;
        s2_next.vx   = s1_reg.vx;
        s2_next.vy   = s1_reg.vy;
        s2_next.ax   = s1_reg.ax;
        s2_next.ay   = s1_reg.ay;
    end

    always_comb begin
        s3_next.uu  = tcc_pkg::SQ_W'(unsigned'(s2_reg.uxux))
                    + tcc_pkg::SQ_W'(unsigned'(s2_reg.uyuy));
        s3_next.vv  = tcc_pkg::SQ_W'(unsigned'(s2_reg.vxvx))
                    + tcc_pkg::SQ_W'(unsigned'(s2_reg.vyvy));
        s3_next.det = (tcc_pkg::DET_W'(s2_reg.uxvy) - tcc_pkg::DET_W'(s2_reg.uyvx)) <<< 1;
        s3_next.ux  = s2_reg.ux;
        s3_next.uy  = s2_reg.uy;
        s3_next.vx  = s2_reg.vx;
        s3_next.vy  = s2_reg.vy;
        s3_next.ax  = s2_reg.ax;
        s3_next.ay  = s2_reg.ay;
    end

    always_comb begin
        s4_next.l_uuvy = part_mul(tcc_pkg::HIGH_W'(s3_reg.uu[tcc_pkg::HALF_W-1:0]), s3_reg.vy);
        s4_next.h_uuvy = part_mul(s3_reg.uu[tcc_pkg::SQ_W-1:tcc_pkg::HALF_W], s3_reg.vy);
        s4_next.l_vvuy = part_mul(tcc_pkg::HIGH_W'(s3_reg.vv[tcc_pkg::HALF_W-1:0]), s3_reg.uy);
        s4_next.h_vvuy = part_mul(s3_reg.vv[tcc_pkg::SQ_W-1:tcc_pkg::HALF_W], s3_reg.uy);
        s4_next.l_vvux = part_mul(tcc_pkg::HIGH_W'(s3_reg.vv[tcc_pkg::HALF_W-1:0]), s3_reg.ux);
        s4_next.h_vvux = part_mul(s3_reg.vv[tcc_pkg::SQ_W-1:tcc_pkg::HALF_W], s3_reg.ux);
        s4_next.l_uuvx = part_mul(tcc_pkg::HIGH_W'(s3_reg.uu[tcc_pkg::HALF_W-1:0]), s3_reg.vx);
        s4_next.h_uuvx = part_mul(s3_reg.uu[tcc_pkg::SQ_W-1:tcc_pkg::HALF_W], s3_reg.vx);
        s4_next.det    = s3_reg.det;
        s4_next.ax     = s3_reg.ax;
        s4_next.ay     = s3_reg.ay;
    end

    always_comb begin
        s5_next.uuvy = join_parts(s4_reg.l_uuvy, s4_reg.h_uuvy);
        s5_next.vvuy = join_parts(s4_reg.l_vvuy, s4_reg.h_vvuy);
        s5_next.vvux = join_parts(s4_reg.l_vvux, s4_reg.h_vvux);
        s5_next.uuvx = join_parts(s4_reg.l_uuvx, s4_reg.h_uuvx);
        s5_next.det  = s4_reg.det;
        s5_next.ax   = s4_reg.ax;
        s5_next.ay   = s4_reg.ay;
    end

    logic signed [tcc_pkg::NUM_W-1:0] nx, ny;

    always_comb begin
        nx = (tcc_pkg::NUM_W'(s5_reg.uuvy) - tcc_pkg::NUM_W'(s5_reg.vvuy)) <<< tcc_pkg::SCALE_SH;
        ny = (tcc_pkg::NUM_W'(s5_reg.vvux) - tcc_pkg::NUM_W'(s5_reg.uuvx)) <<< tcc_pkg::SCALE_SH;
        s6_next.nmx   = nx[tcc_pkg::NUM_W-1] ? unsigned'(-nx) : unsigned'(nx);
        s6_next.nmy   = ny[tcc_pkg::NUM_W-1] ? unsigned'(-ny) : unsigned'(ny);
        s6_next.negx  = nx[tcc_pkg::NUM_W-1] ^ s5_reg.det[tcc_pkg::DET_W-1];
        s6_next.negy  = ny[tcc_pkg::NUM_W-1] ^ s5_reg.det[tcc_pkg::DET_W-1];
        s6_next.dm    = s5_reg.det[tcc_pkg::DET_W-1] ? unsigned'(-s5_reg.det)
                                                     : unsigned'(s5_reg.det);
        s6_next.ax    = s5_reg.ax;
        s6_next.ay    = s5_reg.ay;
        s6_next.degen = (s5_reg.det == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctl.adv) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_data  = s6_reg;

endmodule
`default_nettype wire

### rtl/core/tcc_div.sv
`default_nettype none
module tcc_div (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire tcc_pkg::tcc_ctl_t   ctl,
    input  wire                      in_valid,
    input  wire tcc_pkg::tcc_num_t   in_data,
    output logic                     out_valid,
    output tcc_pkg::tcc_quo_t        out_data
);

    localparam int N = tcc_pkg::NUM_W;
    localparam int D = tcc_pkg::DET_W;

    typedef struct packed {
        logic [N-1:0]                           nmx, nmy;
        logic [N-1:0]                           qx, qy;
        logic [D-1:0]                           rx, ry;
        logic                                   negx, negy;
        logic [D-1:0]                           dm;
        logic signed [tcc_pkg::COORD_WIDTH-1:0] ax, ay;
        logic                                   degen;
    } dst_t;

    typedef struct packed {
        logic [N-1:0] nm;
        logic [N-1:0] q;
        logic [D-1:0] r;
    } lane_t;

    // One restoring step: bring down the next numerator bit, subtract if it fits.
    function automatic lane_t div_step(input lane_t cur, input logic [D-1:0] dm);
        logic [D:0] rs;
        lane_t      nxt;
        rs     = {cur.r, cur.nm[N-1]};
        nxt.nm = cur.nm << 1;
        if (rs >= {1'b0, dm}) begin
            nxt.r = D'(rs - {1'b0, dm});
            nxt.q = {cur.q[N-2:0], 1'b1};
        end else begin
            nxt.r = rs[D-1:0];
            nxt.q = {cur.q[N-2:0], 1'b0};
        end
        return nxt;
    endfunction

    dst_t       st_reg [N];
    logic [N-1:0] vld_reg;
    dst_t       st_init;

    always_comb begin
        st_init.nmx   = in_data.nmx;
        st_init.nmy   = in_data.nmy;
        st_init.qx    = '0;
        st_init.qy    = '0;
        st_init.rx    = '0;
        st_init.ry    = '0;
        st_init.negx  = in_data.negx;
        st_init.negy  = in_data.negy;
        st_init.dm    = in_data.dm;
        st_init.ax    = in_data.ax;
        st_init.ay    = in_data.ay;
        st_init.degen = in_data.degen;
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        dst_t  prev, st_next;
        lane_t lx, ly;

        assign prev = (k == 0) ? st_init : st_reg[(k == 0) ? 0 : k - 1];

        always_comb begin
            lx = div_step('{nm: prev.nmx, q: prev.qx, r: prev.rx}, prev.dm);
            ly = div_step('{nm: prev.nmy, q: prev.qy, r: prev.ry}, prev.dm);
            st_next     = prev;
            st_next.nmx = lx.nm;
            st_next.qx  = lx.q;
            st_next.rx  = lx.r;
            st_next.nmy = ly.nm;
            st_next.qy  = ly.q;
            st_next.ry  = ly.r;
        end

        always_ff @(posedge aclk) begin
            if (ctl.adv) begin
                st_reg[k] <= st_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctl.adv) begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    assign out_valid      = vld_reg[N-1];
    assign out_data.qx    = st_reg[N-1].qx;
    assign out_data.qy    = st_reg[N-1].qy;
    assign out_data.rx    = st_reg[N-1].rx;
    assign out_data.ry    = st_reg[N-1].ry;
    assign out_data.negx  = st_reg[N-1].negx;
    assign out_data.negy  = st_reg[N-1].negy;
    assign out_data.dm    = st_reg[N-1].dm;
    assign out_data.ax    = st_reg[N-1].ax;
    assign out_data.ay    = st_reg[N-1].ay;
    assign out_data.degen = st_reg[N-1].degen;

endmodule
`default_nettype wire

### rtl/core/tcc_back.sv
`default_nettype none
module tcc_back (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire tcc_pkg::tcc_ctl_t   ctl,
    input  wire                      in_valid,
    input  wire tcc_pkg::tcc_quo_t   in_data,
    output logic                     out_valid,
    output tcc_pkg::tcc_out_t        out_data
);

    typedef struct packed {
        logic signed [tcc_pkg::OFS_W-1:0]       qsx, qsy;
        logic signed [tcc_pkg::COORD_WIDTH-1:0] ax, ay;
        logic                                   degen;
    } bst1_t;

    typedef struct packed {
        logic signed [tcc_pkg::CEN_W-1:0] cen_x, cen_y;
        logic                             sat_c;
        logic                             big;
        logic [tcc_pkg::RSQ_W-1:0]        sqx, sqy;
        logic                             degen;
    } bst2_t;

    bst1_t b1_reg, b1_next;
    bst2_t b2_reg, b2_next;
    tcc_pkg::tcc_out_t b3_reg, b3_next;
    logic [2:0] vld_reg;

    // Round half away from zero, hold the magnitude at the offset limit, apply sign.
    function automatic logic signed [tcc_pkg::OFS_W-1:0] round_off(
        input logic [tcc_pkg::NUM_W-1:0] q,
        input logic [tcc_pkg::DET_W-1:0] r,
        input logic [tcc_pkg::DET_W-1:0] dm,
        input logic                      neg
    );
        logic [tcc_pkg::QUO_W-1:0] qr;
        logic [tcc_pkg::MAG_W-1:0] mag;
        qr  = tcc_pkg::QUO_W'(q) + tcc_pkg::QUO_W'({r, 1'b0} >= {1'b0, dm});
        mag = (qr > tcc_pkg::OFS_LIMIT) ? tcc_pkg::MAG_W'(tcc_pkg::OFS_LIMIT)
                                        : qr[tcc_pkg::MAG_W-1:0];
        return neg ? -$signed(tcc_pkg::OFS_W'(mag)) : $signed(tcc_pkg::OFS_W'(mag));
    endfunction

    function automatic logic [tcc_pkg::CEN_W:0] clip_center(
        input logic signed [tcc_pkg::COORD_WIDTH-1:0] a,
        input logic signed [tcc_pkg::OFS_W-1:0]       qs
    );
        logic signed [tcc_pkg::CSUM_W-1:0] sum;
        logic signed [tcc_pkg::CSUM_W-1:0] hi_lim, lo_lim;
        hi_lim = tcc_pkg::CSUM_W'({1'b0, {(tcc_pkg::CEN_W-1){1'b1}}});
        lo_lim = -hi_lim - tcc_pkg::CSUM_W'(1);
        sum = (tcc_pkg::CSUM_W'(a) <<< tcc_pkg::SCALE_SH) + tcc_pkg::CSUM_W'(qs);
        if (sum > hi_lim) begin
            return {1'b1, hi_lim[tcc_pkg::CEN_W-1:0]};
        end else if (sum < lo_lim) begin
            return {1'b1, lo_lim[tcc_pkg::CEN_W-1:0]};
        end
        return {1'b0, sum[tcc_pkg::CEN_W-1:0]};
    endfunction

    logic [tcc_pkg::MAG_W-1:0] mx, my;
    logic [tcc_pkg::CEN_W:0]   clx, cly;

    always_comb begin
        b1_next.qsx   = round_off(in_data.qx, in_data.rx, in_data.dm, in_data.negx);
        b1_next.qsy   = round_off(in_data.qy, in_data.ry, in_data.dm, in_data.negy);
        b1_next.ax    = in_data.ax;
        b1_next.ay    = in_data.ay;
        b1_next.degen = in_data.degen;
    end

    always_comb begin
        clx = clip_center(b1_reg.ax, b1_reg.qsx);
        cly = clip_center(b1_reg.ay, b1_reg.qsy);
        mx  = b1_reg.qsx[tcc_pkg::OFS_W-1] ? tcc_pkg::MAG_W'(-b1_reg.qsx)
                                           : tcc_pkg::MAG_W'(b1_reg.qsx);
        my  = b1_reg.qsy[tcc_pkg::OFS_W-1] ? tcc_pkg::MAG_W'(-b1_reg.qsy)
                                           : tcc_pkg::MAG_W'(b1_reg.qsy);
        b2_next.cen_x = $signed(clx[tcc_pkg::CEN_W-1:0]);
        b2_next.cen_y = $signed(cly[tcc_pkg::CEN_W-1:0]);
        b2_next.sat_c = clx[tcc_pkg::CEN_W] | cly[tcc_pkg::CEN_W];
        b2_next.big   = (mx[tcc_pkg::MAG_W-1:tcc_pkg::SQR_W] != '0)
                      | (my[tcc_pkg::MAG_W-1:tcc_pkg::SQR_W] != '0);
        b2_next.sqx   = mx[tcc_pkg::SQR_W-1:0] * mx[tcc_pkg::SQR_W-1:0];
        b2_next.sqy   = my[tcc_pkg::SQR_W-1:0] * my[tcc_pkg::SQR_W-1:0];
        b2_next.degen = b1_reg.degen;
    end

    localparam int OUT_SH_W = tcc_pkg::OUT_FRAC;
    logic [tcc_pkg::RSUM_W-1:0]          rsum;
    logic [tcc_pkg::RSUM_W-OUT_SH_W-1:0] rad;

    always_comb begin
        rsum = tcc_pkg::RSUM_W'(b2_reg.sqx) + tcc_pkg::RSUM_W'(b2_reg.sqy) + tcc_pkg::RAD_HALF;
        rad  = rsum[tcc_pkg::RSUM_W-1:OUT_SH_W];
        b3_next.center_x   = b2_reg.cen_x;
        b3_next.center_y   = b2_reg.cen_y;
        b3_next.degenerate = 1'b0;
        if (b2_reg.big || (rad > (tcc_pkg::RSUM_W - OUT_SH_W)'(tcc_pkg::RAD_MAX))) begin
            b3_next.radius_sq = tcc_pkg::RAD_MAX;
            b3_next.saturated = 1'b1;
        end else begin
            b3_next.radius_sq = rad[tcc_pkg::RAD_W-1:0];
            b3_next.saturated = b2_reg.sat_c;
        end
        if (b2_reg.degen) begin
            b3_next.center_x   = '0;
            b3_next.center_y   = '0;
            b3_next.radius_sq  = '0;
            b3_next.degenerate = 1'b1;
            b3_next.saturated  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctl.adv) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            b1_reg <= b1_next;
            b2_reg <= b2_next;
            b3_reg <= b3_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = b3_reg;

endmodule
`default_nettype wire
